// ===== rtl/vmx_pkg.sv =====
// Shared constants, codes and transfer types of the voice mixer.
package vmx_pkg;

  localparam int VOICES     = 8;
  localparam int MEM_DEPTH  = 65536;
  localparam int FADE_TICKS = 10000;

  localparam int ADDR_W  = $clog2(MEM_DEPTH);
  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCNT_W  = $clog2(VOICES + 1);
  localparam int FC_W    = $clog2(FADE_TICKS + 1);
  localparam int SUM_W   = 16 + VCNT_W;
  localparam int FTERM_W = 17;
  localparam int MIX_W   = SUM_W + 2;

  localparam logic [7:0]         UNITY_LEVEL  = 8'hff;
  localparam logic [15:0]        WINDOW_RESET = 16'd3000;
  localparam logic signed [15:0] SAMPLE_MIN   = 16'sh8000;
  localparam logic signed [15:0] SAMPLE_MAX   = 16'sh7fff;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_START = 2'd1,
    MODE_FADE  = 2'd2,
    MODE_TICK  = 2'd3
  } vmx_mode_e;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_DUP    = 2'd1,
    STAT_NOFREE = 2'd2
  } vmx_status_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        mem_address;
    logic signed [15:0] mem_data;
    logic [15:0]        effect_base;
    logic [16:0]        effect_length;
    logic [7:0]         effect_level;
    logic signed [15:0] song_sample;
    logic               song_on;
    logic signed [15:0] old_song_sample;
  } vmx_in_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic [1:0]         status;
  } vmx_out_t;

  typedef struct packed {
    logic wr_mem;
    logic start;
    logic tick;
  } vmx_vctl_t;

  typedef struct packed {
    logic                    done;
    logic [1:0]              status;
    logic signed [SUM_W-1:0] sum;
  } vmx_vstat_t;

  typedef struct packed {
    logic load;
    logic tick;
  } vmx_fctl_t;

  typedef struct packed {
    logic                      done;
    logic signed [FTERM_W-1:0] term;
  } vmx_fstat_t;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] length;
    logic [16:0] pos;
    logic [7:0]  gain;
  } vmx_voice_t;

endpackage

// ===== rtl/vmx_voice_unit.sv =====
// Voice memory, sample memory and the per-voice sweep for ticks and effect starts.
module vmx_voice_unit import vmx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vmx_vctl_t   ctrl_i,
  input  vmx_in_t     req_i,
  input  logic [15:0] window_i,
  output vmx_vstat_t  stat_o
);

  localparam int AS_W = (ADDR_W > 18) ? ADDR_W : 18;

  vmx_voice_t        vmem [VOICES];
  logic [15:0]       smem [MEM_DEPTH];

  logic [VOICES-1:0] used_q;
  logic              run_q;
  logic              is_tick_q;
  logic [VCNT_W-1:0] cnt_q;
  logic              p1_valid_q;
  logic [VIDX_W-1:0] p1_idx_q;
  vmx_voice_t        vrd_q;
  logic              p2_valid_q;
  logic [7:0]        p2_gain_q;
  logic signed [15:0] srd_q;
  logic signed [SUM_W-1:0] sum_q;
  logic              dup_q;
  logic              found_q;
  logic [VIDX_W-1:0] pick_q;

  logic              issue;
  logic              p1_used;
  logic              p1_active;
  logic              p1_dup;
  logic              adv;
  logic              drained;
  logic              place;
  logic [AS_W-1:0]   a_full;
  logic [ADDR_W-1:0] saddr;
  logic              vwr_en;
  logic [VIDX_W-1:0] vwr_idx;
  vmx_voice_t        vwr_data;
  logic signed [24:0] prod;
  logic signed [15:0] scaled;
  logic [1:0]        status;

  assign issue     = run_q && (cnt_q < VCNT_W'(VOICES));
  assign p1_used   = used_q[p1_idx_q];
  assign p1_active = p1_used && (vrd_q.pos < vrd_q.length);
  assign p1_dup    = p1_used && (vrd_q.base == req_i.effect_base) &&
                     (vrd_q.pos <= {1'b0, window_i});
  assign adv       = p1_valid_q && is_tick_q && p1_active;
  assign drained   = run_q && !issue && !p1_valid_q && !p2_valid_q;
  assign place     = drained && !is_tick_q && !dup_q && found_q;

  assign a_full = AS_W'(vrd_q.base) + AS_W'(vrd_q.pos);
  assign saddr  = a_full[ADDR_W-1:0];

  always_comb begin
    vwr_en   = adv || place;
    vwr_idx  = adv ? p1_idx_q : pick_q;
    vwr_data = vrd_q;
    if (adv) begin
      vwr_data.pos = vrd_q.pos + 17'd1;
    end else begin
      vwr_data.base   = req_i.effect_base;
      vwr_data.length = req_i.effect_length;
      vwr_data.pos    = '0;
      vwr_data.gain   = req_i.effect_level;
    end
  end

  assign prod   = srd_q * $signed({1'b0, p2_gain_q});
  assign scaled = (p2_gain_q == UNITY_LEVEL) ? srd_q : prod[23:8];

  always_comb begin
    if (is_tick_q) begin
      status = STAT_DONE;
    end else if (dup_q) begin
      status = STAT_DUP;
    end else if (!found_q) begin
      status = STAT_NOFREE;
    end else begin
      status = STAT_DONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      vrd_q <= vmem[cnt_q[VIDX_W-1:0]];
    end
    if (vwr_en) begin
      vmem[vwr_idx] <= vwr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      srd_q <= smem[saddr];
    end
    if (ctrl_i.wr_mem) begin
      smem[ADDR_W'(req_i.mem_address)] <= req_i.mem_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      run_q      <= 1'b0;
      is_tick_q  <= 1'b0;
      cnt_q      <= '0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      dup_q      <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      p1_valid_q <= issue;
      p2_valid_q <= adv;
      if (ctrl_i.tick || ctrl_i.start) begin
        run_q     <= 1'b1;
        is_tick_q <= ctrl_i.tick;
        cnt_q     <= '0;
        dup_q     <= 1'b0;
        found_q   <= 1'b0;
      end else begin
        if (issue) begin
          cnt_q <= cnt_q + VCNT_W'(1);
        end
        if (p1_valid_q && !is_tick_q) begin
          if (p1_dup) begin
            dup_q <= 1'b1;
          end
          if (!p1_active && !found_q) begin
            found_q <= 1'b1;
          end
        end
        if (drained) begin
          run_q <= 1'b0;
        end
        if (place) begin
          used_q[pick_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q  <= cnt_q[VIDX_W-1:0];
    p2_gain_q <= vrd_q.gain;
    if (p1_valid_q && !is_tick_q && !p1_active && !found_q) begin
      pick_q <= p1_idx_q;
    end
    if (ctrl_i.tick || ctrl_i.start) begin
      sum_q <= '0;
    end else if (p2_valid_q) begin
      sum_q <= sum_q + SUM_W'(scaled);
    end
  end

  assign stat_o.done   = drained;
  assign stat_o.status = status;
  assign stat_o.sum    = sum_q;

endmodule

// ===== rtl/vmx_fade.sv =====
// Fade counter and the old-song term: one multiply, then a multiply by the fade length's reciprocal.
module vmx_fade import vmx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vmx_fctl_t          ctrl_i,
  input  logic signed [15:0] old_i,
  output vmx_fstat_t         stat_o
);

  localparam int PW = 17 + FC_W;
  localparam int QW = 16;
  localparam int SH = PW + $clog2(FADE_TICKS);
  localparam int RW = PW + 1;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(FADE_TICKS) - 64'd1) / 64'(FADE_TICKS));

  logic [FC_W-1:0] fc_q;
  logic            busy_q;
  logic            done_q;
  logic            neg_q;
  logic [PW-1:0]   prod_q;
  logic [QW-1:0]   quo_q;

  logic signed [16:0] old_x;
  logic [16:0]        mag;
  logic [PW-1:0]      prod;
  logic [PW+RW-1:0]   recip_prod;

  assign old_x      = 17'(old_i);
  assign mag        = old_x[16] ? 17'(-old_x) : 17'(old_x);
  assign prod       = mag * fc_q;
  assign recip_prod = prod_q * RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        fc_q   <= FC_W'(FADE_TICKS);
        busy_q <= 1'b0;
        done_q <= 1'b0;
      end else if (ctrl_i.tick) begin
        busy_q <= (fc_q != '0);
        done_q <= (fc_q == '0);
        if (fc_q != '0) begin
          fc_q <= fc_q - FC_W'(1);
        end
      end else begin
        busy_q <= 1'b0;
        done_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tick) begin
      prod_q <= prod;
      quo_q  <= '0;
      neg_q  <= old_i[15] && (fc_q != '0);
    end else if (busy_q) begin
      quo_q <= recip_prod[SH+QW-1:SH];
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.term = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ===== rtl/voice_mixer_with_crossfade.sv =====
// Top level of the voice mixer: command sequencer, result register and configuration.
//
// Each transfer on the input channel is one command and gives one transfer on the output
// channel. A sample-memory write or a fade start goes from the execute state straight to
// the response state. An effect start sweeps the voice memory one voice per cycle. The
// length of a tick is set by the voice sweep: one voice per cycle through the voice
// memory, then the sample memory, then the sum; the fade term, one multiply and then a
// multiply by the reciprocal of the fade length, runs alongside and finishes earlier.
// One command is worked at a time; the next is taken once the result has moved into the
// output register, even while that register is still stalled.
// The sample memory has no reset and must be written before a voice plays from it.
module voice_mixer_with_crossfade import vmx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  vmx_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output vmx_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e                  state_q;
  vmx_in_t                 req_q;
  logic [15:0]             window_q;
  logic                    vwait_q;
  logic                    fwait_q;
  logic signed [SUM_W-1:0] res_sum_q;
  logic signed [FTERM_W-1:0] res_term_q;
  logic [1:0]              res_stat_q;
  logic                    out_valid_q;
  vmx_out_t                out_data_q;

  vmx_vctl_t               vctl;
  vmx_vstat_t              vstat;
  vmx_fctl_t               fctl;
  vmx_fstat_t              fstat;
  vmx_mode_e               mode;
  logic                    accept;
  logic                    out_free;
  logic                    v_left;
  logic                    f_left;
  logic signed [MIX_W-1:0] song_x;
  logic signed [MIX_W-1:0] mix_w;
  logic signed [15:0]      mix_sat;

  assign mode        = vmx_mode_e'(req_q.mode);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign v_left      = vwait_q && !vstat.done;
  assign f_left      = fwait_q && !fstat.done;

  always_comb begin
    vctl.wr_mem = (state_q == ST_EXEC) && (mode == MODE_WRITE);
    vctl.start  = (state_q == ST_EXEC) && (mode == MODE_START);
    vctl.tick   = (state_q == ST_EXEC) && (mode == MODE_TICK);
    fctl.load   = (state_q == ST_EXEC) && (mode == MODE_FADE);
    fctl.tick   = (state_q == ST_EXEC) && (mode == MODE_TICK);
  end

  vmx_voice_unit u_voice (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (vctl),
    .req_i    (req_q),
    .window_i (window_q),
    .stat_o   (vstat)
  );

  vmx_fade u_fade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fctl),
    .old_i  (req_q.old_song_sample),
    .stat_o (fstat)
  );

  assign song_x = ((mode == MODE_TICK) && req_q.song_on) ? MIX_W'(req_q.song_sample) : '0;
  assign mix_w  = MIX_W'(res_sum_q) + song_x + MIX_W'(res_term_q);

  always_comb begin
    if (mix_w > MIX_W'(SAMPLE_MAX)) begin
      mix_sat = SAMPLE_MAX;
    end else if (mix_w < MIX_W'(SAMPLE_MIN)) begin
      mix_sat = SAMPLE_MIN;
    end else begin
      mix_sat = 16'(mix_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vwait_q     <= 1'b0;
      fwait_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          vwait_q <= (mode == MODE_START) || (mode == MODE_TICK);
          fwait_q <= (mode == MODE_TICK);
          if ((mode == MODE_START) || (mode == MODE_TICK)) begin
            state_q <= ST_RUN;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_RUN: begin
          if (vstat.done) begin
            vwait_q <= 1'b0;
          end
          if (fstat.done) begin
            fwait_q <= 1'b0;
          end
          if (!v_left && !f_left) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (state_q == ST_EXEC) begin
      res_sum_q  <= '0;
      res_term_q <= '0;
      res_stat_q <= STAT_DONE;
    end else if (state_q == ST_RUN) begin
      if (vstat.done) begin
        res_sum_q  <= vstat.sum;
        res_stat_q <= vstat.status;
      end
      if (fstat.done) begin
        res_term_q <= fstat.term;
      end
    end
    if ((state_q == ST_RESP) && out_free) begin
      out_data_q.mixed_sample <= mix_sat;
      out_data_q.status       <= res_stat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted command did not move to execution");

  a_voice_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vstat.done |-> state_q == ST_RUN)
    else $error("voice sweep finished outside the run state");

  a_fade_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.done |-> state_q == ST_RUN)
    else $error("fade term finished outside the run state");

  a_status_zero_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STAT_DONE) |-> out_data_o.mixed_sample == '0)
    else $error("failed effect start carries a nonzero mix");

endmodule
